@@ src/exposure_countdown_timer_assert.svh @@
// ----------------------------------------------------------------------------
// Exposure countdown timer assertion macros
// Shared property macros for the checker. They expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef EXPOSURE_COUNTDOWN_TIMER_ASSERT_SVH
`define EXPOSURE_COUNTDOWN_TIMER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define ECT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ect assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ECT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ect assertion failed");

`endif

@@ src/ect_pkg.sv @@
// ----------------------------------------------------------------------------
// Exposure countdown timer package
// Shared codes, constants and the configuration bundle.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 2;
  localparam int unsigned ModW  = 10;

  localparam logic [OpW-1:0] OpTick   = 3'd0;
  localparam logic [OpW-1:0] OpStart  = 3'd1;
  localparam logic [OpW-1:0] OpPause  = 3'd2;
  localparam logic [OpW-1:0] OpResume = 3'd3;
  localparam logic [OpW-1:0] OpStop   = 3'd4;
  localparam logic [OpW-1:0] OpClear  = 3'd5;

  localparam logic [StW-1:0] StStopped = 2'd0;
  localparam logic [StW-1:0] StRunning = 2'd1;
  localparam logic [StW-1:0] StPaused  = 2'd2;

  localparam logic CfgBeepVolume = 1'b0;
  localparam logic CfgLagMs      = 1'b1;

  localparam int unsigned BeepLeadMs   = 100;
  localparam int unsigned BeepMinMs    = 500;
  localparam int unsigned BeepDecades  = 10;
  localparam int unsigned BeepPeriodMs = BeepLeadMs * BeepDecades;

  // Reciprocal of the beep period for 16-bit operands.
  localparam int unsigned LagModShift = 26;
  localparam int unsigned LagModMul   = (1 << LagModShift) / BeepPeriodMs + 1;

  typedef struct packed {
    logic [7:0]      beep_volume;
    logic [15:0]     lag_ms;
    logic [ModW-1:0] lag_mod;
  } cfg_t;

endpackage

@@ src/ect_in_stage.sv @@
// ----------------------------------------------------------------------------
// Exposure countdown timer input stage
// Registers one request and hands it to the core when the core can take it.
// ----------------------------------------------------------------------------
module ect_in_stage import ect_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] op_i,
  input  logic [31:0]    duration_ms_i,
  input  logic           core_free_i,
  output logic           take_o,
  output logic [OpW-1:0] op_o,
  output logic [31:0]    dur_o
);

  logic           valid_q;
  logic [OpW-1:0] op_q;
  logic [31:0]    dur_q;

  assign take_o     = valid_q && core_free_i;
  assign in_ready_o = !valid_q || take_o;
  assign op_o       = op_q;
  assign dur_o      = dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_i;
      dur_q <= duration_ms_i;
    end
  end

endmodule

@@ src/ect_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Exposure countdown timer configuration registers
// Holds the beep volume and the lag, and the lag reduced modulo one second.
// ----------------------------------------------------------------------------
module ect_cfg_regs import ect_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t            cfg_q;
  logic [32:0]     prod;
  logic [6:0]      quot;
  logic [15:0]     quot_scaled;
  logic [15:0]     rem_full;

  assign prod        = {17'b0, cfg_wdata_i} * 33'(LagModMul);
  assign quot        = prod[32:LagModShift];
  assign quot_scaled = {9'b0, quot} * 16'(BeepPeriodMs);
  assign rem_full    = cfg_wdata_i - quot_scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beep_volume <= 8'hFF;
      cfg_q.lag_ms      <= 16'd0;
      cfg_q.lag_mod     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBeepVolume: cfg_q.beep_volume <= cfg_wdata_i[7:0];
        CfgLagMs: begin
          cfg_q.lag_ms  <= cfg_wdata_i;
          cfg_q.lag_mod <= rem_full[ModW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/ect_core.sv @@
// ----------------------------------------------------------------------------
// Exposure countdown timer core
// Applies one request to the timer state and registers its result.
// ----------------------------------------------------------------------------
module ect_core import ect_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [OpW-1:0] op_i,
  input  logic [31:0]    dur_i,
  input  cfg_t           cfg_i,
  input  logic           out_ready_i,
  output logic           free_o,
  output logic           out_valid_o,
  output logic [7:0]     beep_level_o,
  output logic           relay_on_o,
  output logic [StW-1:0] state_code_o,
  output logic [31:0]    time_left_ms_o,
  output logic [31:0]    total_ms_o,
  output logic           in_lag_o
);

  logic [31:0]     now_q, now_d;
  logic [StW-1:0]  run_q, run_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     stop_q, stop_d;
  logic [31:0]     acc_q, acc_d;
  logic [7:0]      beep_q, beep_d;
  logic [31:0]     el_q, el_d;
  logic [ModW-1:0] emod_q, emod_d;

  logic            out_valid_q;
  logic [7:0]      beep_out_q;
  logic [StW-1:0]  state_out_q;
  logic [31:0]     left_out_q;
  logic [31:0]     total_out_q;
  logic            lag_out_q;

  logic            running;
  logic [32:0]     diff;
  logic            el_ge_lag;
  logic [31:0]     c_cur;
  logic [31:0]     c_new;
  logic [31:0]     el_new;
  logic [ModW-1:0] emod_new;
  logic [ModW:0]   m_raw;
  logic [ModW-1:0] m_sec;
  logic [7:0]      beep_tick;
  logic [31:0]     end_t;
  logic            past_end;
  logic            tick_end;
  logic [31:0]     c_out;
  logic            run_next;
  logic [31:0]     left_d;
  logic [31:0]     total_d;

  assign running   = (run_q == StRunning);
  assign diff      = {1'b0, el_q} - {17'b0, cfg_i.lag_ms};
  assign el_ge_lag = !diff[32];
  assign c_cur     = (running && el_ge_lag) ? diff[31:0] : 32'd0;
  assign c_new     = (running && el_ge_lag && !(&el_q)) ? diff[31:0] + 32'd1 : 32'd0;
  assign el_new    = el_q + 32'd1;

  always_comb begin
    if ((&el_q) || (emod_q == ModW'(BeepPeriodMs - 1))) begin
      emod_new = '0;
    end else begin
      emod_new = emod_q + ModW'(1);
    end
  end

  assign m_raw = {1'b0, emod_new} - {1'b0, cfg_i.lag_mod};
  assign m_sec = m_raw[ModW] ? m_raw[ModW-1:0] + ModW'(BeepPeriodMs) : m_raw[ModW-1:0];

  always_comb begin
    if (el_new < 32'(BeepLeadMs)) begin
      beep_tick = cfg_i.beep_volume;
    end else if (c_new < 32'(BeepMinMs) || m_sec >= ModW'(BeepLeadMs)) begin
      beep_tick = 8'd0;
    end else begin
      beep_tick = cfg_i.beep_volume;
    end
  end

  assign end_t    = stop_q + {16'b0, cfg_i.lag_ms};
  assign past_end = (now_q >= end_t);
  assign tick_end = past_end && !(&now_q);

  always_comb begin
    now_d  = now_q;
    run_d  = run_q;
    rem_d  = rem_q;
    stop_d = stop_q;
    acc_d  = acc_q;
    beep_d = beep_q;
    el_d   = el_q;
    emod_d = emod_q;
    c_out  = c_cur;
    unique case (op_i)
      OpTick: begin
        now_d = now_q + 32'd1;
        if (running) begin
          el_d   = el_new;
          emod_d = emod_new;
          if (tick_end) begin
            beep_d = 8'd0;
            acc_d  = acc_q + rem_q;
            run_d  = StStopped;
            rem_d  = 32'd0;
            c_out  = 32'd0;
          end else begin
            beep_d = beep_tick;
            c_out  = c_new;
          end
        end
      end
      OpStart: begin
        rem_d  = dur_i;
        stop_d = now_q + dur_i;
        run_d  = StRunning;
        el_d   = 32'd0;
        emod_d = '0;
        c_out  = 32'd0;
      end
      OpPause: begin
        if (running) begin
          beep_d = 8'd0;
          acc_d  = acc_q + c_cur;
          rem_d  = rem_q - c_cur;
          run_d  = StPaused;
          c_out  = 32'd0;
        end
      end
      OpResume: begin
        if (run_q == StPaused) begin
          stop_d = now_q + rem_q;
          run_d  = StRunning;
          el_d   = 32'd0;
          emod_d = '0;
          c_out  = 32'd0;
        end
      end
      OpStop: begin
        if (run_q != StStopped) begin
          beep_d = 8'd0;
          acc_d  = acc_q + (past_end ? rem_q : c_cur);
          run_d  = StStopped;
          rem_d  = 32'd0;
          c_out  = 32'd0;
        end
      end
      OpClear: begin
        acc_d = 32'd0;
      end
      default: ;
    endcase
  end

  assign run_next = (run_d == StRunning);
  assign left_d   = (run_next && (c_out != 32'd0)) ? rem_d - c_out : rem_d;
  assign total_d  = acc_d + c_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= 32'd0;
      run_q  <= StStopped;
      rem_q  <= 32'd0;
      stop_q <= 32'd0;
      acc_q  <= 32'd0;
      beep_q <= 8'd0;
      el_q   <= 32'd0;
      emod_q <= '0;
    end else if (take_i) begin
      now_q  <= now_d;
      run_q  <= run_d;
      rem_q  <= rem_d;
      stop_q <= stop_d;
      acc_q  <= acc_d;
      beep_q <= beep_d;
      el_q   <= el_d;
      emod_q <= emod_d;
    end
  end

  assign free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      beep_out_q  <= beep_d;
      state_out_q <= run_d;
      left_out_q  <= left_d;
      total_out_q <= total_d;
      lag_out_q   <= run_next && (c_out == 32'd0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign beep_level_o   = beep_out_q;
  assign relay_on_o     = (state_out_q == StRunning);
  assign state_code_o   = state_out_q;
  assign time_left_ms_o = left_out_q;
  assign total_ms_o     = total_out_q;
  assign in_lag_o       = lag_out_q;

endmodule

@@ src/exposure_countdown_timer.sv @@
// ----------------------------------------------------------------------------
// Exposure countdown timer
// Millisecond countdown with start, pause, resume, stop and total clear,
// a startup lag, beeper level and relay output.
//
//   Channel   Signals                              Direction
//   in        in_valid_i / in_ready_o, op, dur     request in
//   out       out_valid_o / out_ready_i, result    result out
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i     register write
//
// A request waits in the input register until the core takes it; its
// result then waits in the output register. One request is accepted per
// cycle while the result side does not stall. A stalled result holds the
// core, and the input register then holds one more request. Reset clears
// all timer state.
// ----------------------------------------------------------------------------
module exposure_countdown_timer import ect_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [OpW-1:0] op_i,
  input  logic [31:0]    duration_ms_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     beep_level_o,
  output logic           relay_on_o,
  output logic [StW-1:0] state_code_o,
  output logic [31:0]    time_left_ms_o,
  output logic [31:0]    total_ms_o,
  output logic           in_lag_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);

  cfg_t           cfg;
  logic           core_free;
  logic           take;
  logic [OpW-1:0] op_s;
  logic [31:0]    dur_s;

  ect_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ect_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .duration_ms_i (duration_ms_i),
    .core_free_i   (core_free),
    .take_o        (take),
    .op_o          (op_s),
    .dur_o         (dur_s)
  );

  ect_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .op_i           (op_s),
    .dur_i          (dur_s),
    .cfg_i          (cfg),
    .out_ready_i    (out_ready_i),
    .free_o         (core_free),
    .out_valid_o    (out_valid_o),
    .beep_level_o   (beep_level_o),
    .relay_on_o     (relay_on_o),
    .state_code_o   (state_code_o),
    .time_left_ms_o (time_left_ms_o),
    .total_ms_o     (total_ms_o),
    .in_lag_o       (in_lag_o)
  );

endmodule

@@ src/ect_checker.sv @@
// ----------------------------------------------------------------------------
// Exposure countdown timer checker
// Port-level properties of the timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "exposure_countdown_timer_assert.svh"

module ect_checker import ect_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input logic [7:0]     beep_level_o,
  input logic           relay_on_o,
  input logic [StW-1:0] state_code_o,
  input logic [31:0]    time_left_ms_o,
  input logic [31:0]    total_ms_o,
  input logic           in_lag_o
);

  `ECT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(total_ms_o))
  `ECT_ASSERT_IMP(a_relay_state, out_valid_o, relay_on_o == (state_code_o == StRunning))
  `ECT_ASSERT_IMP(a_lag_running, out_valid_o && in_lag_o, relay_on_o)
  `ECT_ASSERT_IMP(a_idle_silent, out_valid_o && !relay_on_o, beep_level_o == 8'd0)
  `ECT_ASSERT_IMP(a_stopped_clear, out_valid_o && (state_code_o == StStopped),
                  time_left_ms_o == 32'd0)

endmodule

bind exposure_countdown_timer ect_checker u_ect_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Exposure countdown timer testbench
// Drives tick and command requests through the valid/ready input while the
// result side stalls at random. A scoreboard class keeps its own model of the
// timer state and checks every result against the oldest prediction. The run
// goes through several volume and lag settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import ect_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 100;

  typedef struct packed {
    logic [7:0]     beep_level;
    logic           relay_on;
    logic [StW-1:0] state_code;
    logic [31:0]    time_left_ms;
    logic [31:0]    total_ms;
    logic           in_lag;
  } timer_result_t;

  class timer_scoreboard;
    logic [7:0]     volume;
    logic [15:0]    lag;
    logic [31:0]    now_ms;
    logic [31:0]    remain_ms;
    logic [31:0]    stop_at_ms;
    logic [31:0]    total_acc_ms;
    logic [StW-1:0] run_st;
    logic [7:0]     beep;
    timer_result_t  pending_results[$];
    int unsigned    mismatches;

    function new();
      volume       = 8'd255;
      lag          = 16'd0;
      now_ms       = '0;
      remain_ms    = '0;
      stop_at_ms   = '0;
      total_acc_ms = '0;
      run_st       = StStopped;
      beep         = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == CfgBeepVolume) begin
        volume = data[7:0];
      end else begin
        lag = data;
      end
    endfunction

    function logic [31:0] end_ms();
      return stop_at_ms + {16'd0, lag};
    endfunction

    // Exposure counted since the last start or resume, once the lag is over.
    function logic [31:0] counted_ms();
      logic [31:0] span;
      if (run_st != StRunning) return '0;
      span = now_ms + remain_ms - stop_at_ms;
      if (span < {16'd0, lag}) return '0;
      return span - {16'd0, lag};
    endfunction

    function void halt();
      if (run_st == StStopped) return;
      beep = '0;
      if (now_ms >= end_ms()) begin
        total_acc_ms += remain_ms;
      end else begin
        total_acc_ms += counted_ms();
      end
      run_st    = StStopped;
      remain_ms = '0;
    endfunction

    function void tick();
      logic [31:0] since;
      logic [31:0] cnt;
      now_ms += 32'd1;
      if (run_st != StRunning) return;
      since = remain_ms - stop_at_ms + now_ms;
      cnt   = counted_ms();
      if (since < BeepLeadMs) begin
        beep = volume;
      end else if (cnt < BeepMinMs || (cnt / BeepLeadMs) % BeepDecades != 0) begin
        beep = '0;
      end else begin
        beep = volume;
      end
      if (now_ms > end_ms()) halt();
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [31:0] dur);
      logic [31:0]   cnt;
      timer_result_t res;
      case (op)
        OpTick: begin
          tick();
        end
        OpStart: begin
          remain_ms  = dur;
          stop_at_ms = now_ms + dur;
          run_st     = StRunning;
        end
        OpPause: begin
          if (run_st == StRunning) begin
            cnt           = counted_ms();
            beep          = '0;
            total_acc_ms += cnt;
            remain_ms    -= cnt;
            run_st        = StPaused;
          end
        end
        OpResume: begin
          if (run_st == StPaused) begin
            stop_at_ms = now_ms + remain_ms;
            run_st     = StRunning;
          end
        end
        OpStop: begin
          halt();
        end
        OpClear: begin
          total_acc_ms = '0;
        end
        default: begin
        end
      endcase
      cnt              = counted_ms();
      res.beep_level   = beep;
      res.relay_on     = (run_st == StRunning);
      res.state_code   = run_st;
      res.time_left_ms = (run_st == StRunning && cnt != 0) ? end_ms() - now_ms : remain_ms;
      res.total_ms     = total_acc_ms + cnt;
      res.in_lag       = (run_st == StRunning && cnt == 0);
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MaxPrinted) begin
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
      mismatches++;
    endtask

    task check_result(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", got.time_left_ms, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.beep_level !== want.beep_level) begin
        report_mismatch("beep_level", got.beep_level, want.beep_level);
      end
      if (got.relay_on !== want.relay_on) begin
        report_mismatch("relay_on", got.relay_on, want.relay_on);
      end
      if (got.state_code !== want.state_code) begin
        report_mismatch("state_code", got.state_code, want.state_code);
      end
      if (got.time_left_ms !== want.time_left_ms) begin
        report_mismatch("time_left_ms", got.time_left_ms, want.time_left_ms);
      end
      if (got.total_ms !== want.total_ms) begin
        report_mismatch("total_ms", got.total_ms, want.total_ms);
      end
      if (got.in_lag !== want.in_lag) begin
        report_mismatch("in_lag", got.in_lag, want.in_lag);
      end
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  logic [OpW-1:0] op_i;
  logic [31:0]    duration_ms_i;
  logic           out_valid_o;
  logic           out_ready_i;
  logic [7:0]     beep_level_o;
  logic           relay_on_o;
  logic [StW-1:0] state_code_o;
  logic [31:0]    time_left_ms_o;
  logic [31:0]    total_ms_o;
  logic           in_lag_o;
  logic           cfg_we_i;
  logic           cfg_idx_i;
  logic [15:0]    cfg_wdata_i;

  timer_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_req;

  exposure_countdown_timer DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("[exposure_countdown_timer] ERROR");
    $finish;
  end

  // The result side runs on its own; a hold request keeps ready low for a
  // long stretch so that the block fills up and stalls new requests.
  initial begin : receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result({beep_level_o, relay_on_o, state_code_o, time_left_ms_o,
                         total_ms_o, in_lag_o});
      end
      if (hold_req) begin
        hold_left = 120;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_req(logic [OpW-1:0] op, logic [31:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    duration_ms_i <= dur;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, dur);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [7:0] vol, logic [15:0] lag_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgBeepVolume;
    cfg_wdata_i <= {8'd0, vol};
    @(posedge clk_i);
    cfg_idx_i   <= CfgLagMs;
    cfg_wdata_i <= lag_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(CfgBeepVolume, {8'd0, vol});
    sb.write_reg(CfgLagMs, lag_val);
  endtask

  // Mostly well-formed exposures: a start followed by ticks and the odd
  // command, with some fully random requests mixed in.
  task automatic random_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    logic [31:0] dur;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          dur = $urandom_range(60);
        end else if (pick < 80) begin
          dur = $urandom_range(2500);
        end else if (pick < 92) begin
          dur = $urandom;
        end else begin
          dur = pick[0] ? '1 : '0;
        end
        send_req(OpStart, dur);
        sent++;
        repeat ($urandom_range(60, 1)) begin
          pick = $urandom_range(99);
          if (pick < 82) begin
            send_req(OpTick, $urandom);
          end else if (pick < 87) begin
            send_req(OpPause, $urandom);
          end else if (pick < 92) begin
            send_req(OpResume, $urandom);
          end else if (pick < 95) begin
            send_req(OpStop, $urandom);
          end else if (pick < 97) begin
            send_req(OpClear, $urandom);
          end else begin
            send_req(OpStart, $urandom_range(300));
          end
          sent++;
        end
      end else begin
        send_req(OpW'($urandom_range(7)), $urandom);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    sb            = new();
    hold_req      = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 47;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OpTick;
    duration_ms_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgBeepVolume;
    cfg_wdata_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_regs(8'hA5, 16'd7);

    // Unused codes and commands that do not apply while stopped.
    send_req(3'd6, 32'hFFFF_FFFF);
    send_req(3'd7, 32'd0);
    send_req(OpPause, 32'd0);
    send_req(OpResume, 32'd0);
    send_req(OpStop, 32'd0);
    // Short exposure that is stopped exactly at its end.
    send_req(OpStart, 32'd3);
    repeat (10) send_req(OpTick, 32'd0);
    send_req(OpStop, 32'd0);
    // Wrapping stop time, restart while running, restart while paused.
    send_req(OpStart, 32'hFFFF_FFFF);
    send_req(OpTick, 32'd0);
    send_req(OpStart, 32'd20);
    send_req(OpPause, 32'd0);
    send_req(OpPause, 32'd0);
    send_req(OpStart, 32'd5);
    send_req(OpResume, 32'd0);
    send_req(OpStop, 32'd0);
    send_req(OpClear, 32'd0);

    random_traffic(300);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 19;
    write_regs(8'd0, 16'hFFFF);
    random_traffic(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(8'hFF, 16'd0);
    // A long exposure reaches the whole-second beeps while the result side
    // first holds off for a long stretch.
    hold_req = 1'b1;
    send_req(OpStart, 32'd1100);
    repeat (1050) send_req(OpTick, $urandom);
    send_req(OpStop, 32'd0);
    drain();

    write_regs(8'h3C, 16'd25);
    random_traffic(100);
    drain();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[exposure_countdown_timer] OK");
    end else begin
      $display("[exposure_countdown_timer] ERROR");
    end
    $finish;
  end

endmodule
